// ----- hdl/nrbh_pkg.sv -----
`default_nettype none
package nrbh_pkg;

  localparam int MAX_BOXES_DEF = 16;

  localparam int POS_W  = 24;
  localparam int QW_W   = 18;
  localparam int HALF_W = 23;
  localparam int SLOT_W = 4;
  localparam int EPS_W  = 16;
  localparam int DIST_W = 24;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int Q_ONE    = 65536;
  localparam int DIST_MAX = 16777215;

  // datapath widths
  localparam int AXIS_W = 36;
  localparam int MB_W   = 26;
  localparam int PROD_W = AXIS_W + MB_W;
  localparam int ACC_W  = 64;
  localparam int E_W    = 48;
  localparam int NUM_W  = E_W + 1;
  localparam int DVD_W  = NUM_W + 16;
  localparam int T_W    = DVD_W + 1;
  localparam int CNT_W  = $clog2(DVD_W);

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic signed [POS_W-1:0] qx;
    logic signed [POS_W-1:0] qy;
    logic signed [POS_W-1:0] qz;
    logic signed [QW_W-1:0]  qw;
    logic [HALF_W-1:0]       hx;
    logic [HALF_W-1:0]       hy;
    logic [HALF_W-1:0]       hz;
  } box_t;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic signed [POS_W-1:0] qsel(input box_t b, input logic [1:0] i);
    logic signed [POS_W-1:0] r;
    case (i)
      2'd0:    r = b.qx;
      2'd1:    r = b.qy;
      default: r = b.qz;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/nearest_ray_box_hit_unit.sv -----
`default_nettype none
// nearest oriented box hit by a ray, Q8.16 fixed point.
// input words: start with in_action low writes one box (center, quaternion,
// half sizes) into slot in_slot and marks it valid; during a load busy stays
// low and no result follows. a load to a slot beyond the table is
// dropped. start with in_action high is a ray query: busy goes high and the
// block walks all slots in order, running the slab test on each valid box
// through one shared multiplier and one radix-2 divider.
// a box whose test misses early, or that has axes parallel to the ray, does
// less work; each slab axis not parallel to the ray runs two 65-step divisions.
// the result word is on out_* for one cycle with out_strobe high, in the cycle
// busy drops; a new word can be taken in that same cycle. the receiver cannot
// stall it.
// cfg_we writes the parallel threshold; write it only while busy is low.
// reset clears all valid marks, sets the threshold to 66 and returns to idle.
module nearest_ray_box_hit_unit #(
  parameter int MAX_BOXES = nrbh_pkg::MAX_BOXES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_action,
  input  wire logic [nrbh_pkg::SLOT_W-1:0]          in_slot,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_pos_z,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_vec_x,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_vec_y,
  input  wire logic signed [nrbh_pkg::POS_W-1:0]    in_vec_z,
  input  wire logic signed [nrbh_pkg::QW_W-1:0]     in_vec_w,
  input  wire logic [nrbh_pkg::HALF_W-1:0]          in_half_x,
  input  wire logic [nrbh_pkg::HALF_W-1:0]          in_half_y,
  input  wire logic [nrbh_pkg::HALF_W-1:0]          in_half_z,
  output logic                                      out_strobe,
  output logic                                      out_hit_found,
  output logic [nrbh_pkg::SLOT_W-1:0]               out_focus_slot,
  output logic [nrbh_pkg::DIST_W-1:0]               out_hit_distance,
  input  wire logic                                 cfg_we,
  input  wire logic [nrbh_pkg::EPS_W-1:0]           cfg_data
);
  localparam int SW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int AXIS_W = nrbh_pkg::AXIS_W;
  localparam int MB_W   = nrbh_pkg::MB_W;
  localparam int PROD_W = nrbh_pkg::PROD_W;
  localparam int ACC_W  = nrbh_pkg::ACC_W;
  localparam int E_W    = nrbh_pkg::E_W;
  localparam int NUM_W  = nrbh_pkg::NUM_W;
  localparam int DVD_W  = nrbh_pkg::DVD_W;
  localparam int T_W    = nrbh_pkg::T_W;
  localparam int CNT_W  = nrbh_pkg::CNT_W;
  localparam int POS_W  = nrbh_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREP, S_MUL, S_ACC, S_FIN, S_SLAB,
    S_DIV, S_DIVEND, S_NEXTAX, S_BOXEND, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_COL, PH_E, PH_F} phase_t;

  state_t                    state_r;
  phase_t                    phase_r;
  logic [MAX_BOXES-1:0]      valid_r;
  logic [SW-1:0]             slot_r;
  logic [nrbh_pkg::EPS_W-1:0] eps_r;

  logic signed [POS_W-1:0]   org_r [3];
  logic signed [POS_W-1:0]   dir_r [3];
  logic signed [POS_W:0]     d_r [3];
  logic signed [AXIS_W-1:0]  ax_r [3];
  logic signed [PROD_W-1:0]  p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [E_W-1:0]     e_r;
  logic signed [E_W-1:0]     f_r;
  logic [1:0]                axis_r;
  logic [1:0]                row_r;
  logic [1:0]                term_r;

  logic [DVD_W-1:0]          dvd_r;
  logic [E_W-1:0]            rem_r;
  logic [E_W-1:0]            dvs_r;
  logic                      qneg_r;
  logic                      second_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [T_W-1:0]     t1_r;
  logic signed [T_W-1:0]     tmin_r;
  logic signed [T_W-1:0]     tmax_r;
  logic                      tmax_inf_r;
  logic                      found_r;
  logic signed [T_W-1:0]     best_r;
  logic [SW-1:0]             best_slot_r;

  // table
  nrbh_pkg::box_t            wr_box;
  nrbh_pkg::box_t            rd_box;
  logic [$bits(nrbh_pkg::box_t)-1:0] rd_word;
  logic                      load_we;
  logic                      rd_en;

  assign busy = (state_r != S_IDLE);
  assign load_we = start && !busy && (in_action == nrbh_pkg::ACT_LOAD) &&
                   (32'(in_slot) < 32'(MAX_BOXES));
  assign rd_en = (state_r == S_SCAN);
  assign rd_box = nrbh_pkg::box_t'(rd_word);

  always_comb begin
    wr_box.cx = in_pos_x;
    wr_box.cy = in_pos_y;
    wr_box.cz = in_pos_z;
    wr_box.qx = in_vec_x;
    wr_box.qy = in_vec_y;
    wr_box.qz = in_vec_z;
    wr_box.qw = in_vec_w;
    wr_box.hx = in_half_x;
    wr_box.hy = in_half_y;
    wr_box.hz = in_half_z;
  end

  nrbh_ram #(
    .WIDTH($bits(nrbh_pkg::box_t)),
    .DEPTH(MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (SW'(in_slot)),
    .wdata (wr_box),
    .re    (rd_en),
    .raddr (slot_r),
    .rdata (rd_word)
  );

  // shared multiplier operand select
  logic                      diag;
  logic                      sub_op;
  logic                      last_term;
  logic [1:0]                u_idx;
  logic [1:0]                v_idx;
  logic [1:0]                k_idx;
  logic signed [POS_W-1:0]   comp;
  logic signed [AXIS_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;

  assign diag  = (row_r == axis_r);
  assign u_idx = nrbh_pkg::inc3(axis_r);
  assign v_idx = nrbh_pkg::inc3(u_idx);
  assign k_idx = 2'(2'd3 - axis_r - row_r);
  assign comp  = (term_r == 2'd0) ? nrbh_pkg::qsel(rd_box, u_idx)
                                  : nrbh_pkg::qsel(rd_box, v_idx);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    sub_op = 1'b0;
    case (phase_r)
      PH_COL: begin
        if (diag) begin
          mul_a = AXIS_W'(comp);
          mul_b = MB_W'(comp);
        end else if (term_r == 2'd0) begin
          mul_a = AXIS_W'(nrbh_pkg::qsel(rd_box, axis_r));
          mul_b = MB_W'(nrbh_pkg::qsel(rd_box, row_r));
        end else begin
          mul_a = AXIS_W'(rd_box.qw);
          mul_b = MB_W'(nrbh_pkg::qsel(rd_box, k_idx));
          sub_op = (row_r == v_idx);
        end
      end
      PH_E: begin
        mul_a = ax_r[term_r];
        mul_b = MB_W'(d_r[term_r]);
      end
      default: begin
        mul_a = ax_r[term_r];
        mul_b = MB_W'(dir_r[term_r]);
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign last_term = (phase_r == PH_COL) ? (term_r == 2'd1) : (term_r == 2'd2);

  // finalize values
  logic signed [AXIS_W-1:0]  ax_sh;
  logic signed [AXIS_W-1:0]  ax_fin;
  logic signed [E_W-1:0]     q_fin;
  assign ax_sh  = AXIS_W'(acc_r >>> 15);
  assign ax_fin = diag ? (AXIS_W'(nrbh_pkg::Q_ONE) - ax_sh) : ax_sh;
  assign q_fin  = E_W'(acc_r >>> 16);

  // slab terms
  logic [nrbh_pkg::HALF_W-1:0] h_sel;
  logic signed [E_W-1:0]     h_e;
  logic [E_W-1:0]            f_abs;
  logic                      par;
  logic                      par_miss;
  logic signed [NUM_W-1:0]   num1;
  logic signed [NUM_W-1:0]   num2;
  logic [NUM_W-1:0]          mag1;
  logic [NUM_W-1:0]          mag2;

  always_comb begin
    case (axis_r)
      2'd0:    h_sel = rd_box.hx;
      2'd1:    h_sel = rd_box.hy;
      default: h_sel = rd_box.hz;
    endcase
  end

  assign h_e      = E_W'($signed({1'b0, h_sel}));
  assign f_abs    = f_r[E_W-1] ? E_W'(-f_r) : E_W'(f_r);
  assign par      = !(f_abs > E_W'(eps_r));
  assign par_miss = (e_r > h_e) || (e_r < -h_e);
  assign num1     = NUM_W'(e_r) - NUM_W'(h_e);
  assign num2     = NUM_W'(e_r) + NUM_W'(h_e);
  assign mag1     = num1[NUM_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
  assign mag2     = num2[NUM_W-1] ? NUM_W'(-num2) : NUM_W'(num2);

  // divider step
  logic [E_W:0]              rem_sh;
  logic [E_W:0]              rem_sub;
  logic                      ge;
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  logic signed [T_W-1:0]     tq_pos;
  logic signed [T_W-1:0]     tq;
  logic signed [T_W-1:0]     t_lo;
  logic signed [T_W-1:0]     t_hi;
  logic signed [T_W-1:0]     tmin_nxt;
  logic signed [T_W-1:0]     tmax_nxt;
  assign tq_pos   = $signed({1'b0, dvd_r});
  assign tq       = qneg_r ? -tq_pos : tq_pos;
  assign t_lo     = (t1_r > tq) ? tq : t1_r;
  assign t_hi     = (t1_r > tq) ? t1_r : tq;
  assign tmax_nxt = (tmax_inf_r || (t_hi < tmax_r)) ? t_hi : tmax_r;
  assign tmin_nxt = (tmin_r < t_lo) ? t_lo : tmin_r;

  logic                      last_slot;
  assign last_slot = (32'(slot_r) == 32'(MAX_BOXES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      eps_r      <= nrbh_pkg::EPS_RESET;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) begin
        eps_r <= cfg_data;
      end
      if (load_we) begin
        valid_r[SW'(in_slot)] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start && (in_action == nrbh_pkg::ACT_QUERY)) begin
            org_r[0]    <= in_pos_x;
            org_r[1]    <= in_pos_y;
            org_r[2]    <= in_pos_z;
            dir_r[0]    <= in_vec_x;
            dir_r[1]    <= in_vec_y;
            dir_r[2]    <= in_vec_z;
            slot_r      <= '0;
            found_r     <= 1'b0;
            best_slot_r <= '0;
            best_r      <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (valid_r[slot_r]) begin
            state_r <= S_PREP;
          end else if (last_slot) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_PREP: begin
          d_r[0]     <= (POS_W+1)'(rd_box.cx) - (POS_W+1)'(org_r[0]);
          d_r[1]     <= (POS_W+1)'(rd_box.cy) - (POS_W+1)'(org_r[1]);
          d_r[2]     <= (POS_W+1)'(rd_box.cz) - (POS_W+1)'(org_r[2]);
          tmin_r     <= '0;
          tmax_r     <= '0;
          tmax_inf_r <= 1'b1;
          axis_r     <= 2'd0;
          row_r      <= 2'd0;
          term_r     <= 2'd0;
          phase_r    <= PH_COL;
          state_r    <= S_MUL;
        end
        S_MUL: begin
          p_r     <= prod;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (term_r == 2'd0) begin
            acc_r <= ACC_W'(p_r);
          end else if (sub_op) begin
            acc_r <= acc_r - ACC_W'(p_r);
          end else begin
            acc_r <= acc_r + ACC_W'(p_r);
          end
          if (last_term) begin
            state_r <= S_FIN;
          end else begin
            term_r  <= term_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          term_r <= 2'd0;
          case (phase_r)
            PH_COL: begin
              ax_r[row_r] <= ax_fin;
              if (row_r == 2'd2) begin
                phase_r <= PH_E;
              end else begin
                row_r <= row_r + 2'd1;
              end
              state_r <= S_MUL;
            end
            PH_E: begin
              e_r     <= q_fin;
              phase_r <= PH_F;
              state_r <= S_MUL;
            end
            default: begin
              f_r     <= q_fin;
              state_r <= S_SLAB;
            end
          endcase
        end
        S_SLAB: begin
          if (par) begin
            state_r <= par_miss ? S_BOXEND : S_NEXTAX;
          end else begin
            dvd_r    <= {mag1, 16'd0};
            rem_r    <= '0;
            dvs_r    <= f_abs;
            qneg_r   <= num1[NUM_W-1] ^ f_r[E_W-1];
            second_r <= 1'b0;
            cnt_r    <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= ge ? rem_sub[E_W-1:0] : rem_sh[E_W-1:0];
          dvd_r <= {dvd_r[DVD_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DVD_W - 1)) begin
            state_r <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          if (!second_r) begin
            t1_r     <= tq;
            dvd_r    <= {mag2, 16'd0};
            rem_r    <= '0;
            qneg_r   <= num2[NUM_W-1] ^ f_r[E_W-1];
            second_r <= 1'b1;
            cnt_r    <= '0;
            state_r  <= S_DIV;
          end else begin
            tmin_r     <= tmin_nxt;
            tmax_r     <= tmax_nxt;
            tmax_inf_r <= 1'b0;
            state_r    <= (tmax_nxt < tmin_nxt) ? S_BOXEND : S_NEXTAX;
          end
        end
        S_NEXTAX: begin
          if (axis_r == 2'd2) begin
            if (!found_r || (tmin_r < best_r)) begin
              found_r     <= 1'b1;
              best_r      <= tmin_r;
              best_slot_r <= slot_r;
            end
            state_r <= S_BOXEND;
          end else begin
            axis_r  <= axis_r + 2'd1;
            row_r   <= 2'd0;
            term_r  <= 2'd0;
            phase_r <= PH_COL;
            state_r <= S_MUL;
          end
        end
        S_BOXEND: begin
          if (last_slot) begin
            state_r <= S_DONE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_DONE: begin
          out_strobe     <= 1'b1;
          out_hit_found  <= found_r;
          out_focus_slot <= found_r ? nrbh_pkg::SLOT_W'(best_slot_r) : '0;
          if (!found_r) begin
            out_hit_distance <= '0;
          end else if (best_r > T_W'(nrbh_pkg::DIST_MAX)) begin
            out_hit_distance <= '1;
          end else begin
            out_hit_distance <= best_r[nrbh_pkg::DIST_W-1:0];
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/nrbh_ram.sv -----
`default_nettype none
module nrbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/nrbh_checker.sv -----
`default_nettype none
module nrbh_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 in_action,
  input wire logic                                 out_strobe,
  input wire logic                                 out_hit_found,
  input wire logic [nrbh_pkg::SLOT_W-1:0]          out_focus_slot,
  input wire logic [nrbh_pkg::DIST_W-1:0]          out_hit_distance
);
  // a query word makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == nrbh_pkg::ACT_QUERY) |=> busy)
    else $error("query not taken");

  // a load word never makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == nrbh_pkg::ACT_LOAD) |=> !busy)
    else $error("load held the block");

  // the result comes exactly when the query ends
  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_strobe == ($past(busy) && !busy)))
    else $error("result not aligned with end of query");

  // a miss reports slot and distance as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_hit_found |-> (out_focus_slot == '0) && (out_hit_distance == '0))
    else $error("miss result not cleared");
endmodule

bind nearest_ray_box_hit_unit nrbh_checker u_nrbh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_strobe       (out_strobe),
  .out_hit_found    (out_hit_found),
  .out_focus_slot   (out_focus_slot),
  .out_hit_distance (out_hit_distance)
);
`default_nettype wire

// ----- sim/tb_nearest_ray_box_hit_unit.sv -----
module tb_nearest_ray_box_hit_unit;
  localparam int SLOT_W = nrbh_pkg::SLOT_W;
  localparam int POS_W  = nrbh_pkg::POS_W;
  localparam int QW_W   = nrbh_pkg::QW_W;
  localparam int HALF_W = nrbh_pkg::HALF_W;
  localparam int EPS_W  = nrbh_pkg::EPS_W;
  localparam int DIST_W = nrbh_pkg::DIST_W;
  localparam longint DIST_MAX = nrbh_pkg::DIST_MAX;
  localparam logic ACT_LOAD  = nrbh_pkg::ACT_LOAD;
  localparam logic ACT_QUERY = nrbh_pkg::ACT_QUERY;
  localparam logic [EPS_W-1:0] EPS_RESET = nrbh_pkg::EPS_RESET;

  typedef struct {
    logic                     action;
    logic [SLOT_W-1:0]        slot;
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [POS_W-1:0]  vx, vy, vz;
    logic signed [QW_W-1:0]   vw;
    logic [HALF_W-1:0]        hx, hy, hz;
  } word_t;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] distance;
  } hit_t;

  localparam longint ONE = 65536;

  logic clk = 1'b0;
  logic rst_n;
  logic start, busy;
  logic in_action;
  logic [SLOT_W-1:0] in_slot;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z, in_vec_x, in_vec_y, in_vec_z;
  logic signed [QW_W-1:0] in_vec_w;
  logic [HALF_W-1:0] in_half_x, in_half_y, in_half_z;
  logic out_strobe, out_hit_found;
  logic [SLOT_W-1:0] out_focus_slot;
  logic [DIST_W-1:0] out_hit_distance;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_data;

  nearest_ray_box_hit_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_slot(in_slot),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_vec_w(in_vec_w), .in_half_x(in_half_x), .in_half_y(in_half_y),
    .in_half_z(in_half_z), .out_strobe(out_strobe), .out_hit_found(out_hit_found),
    .out_focus_slot(out_focus_slot), .out_hit_distance(out_hit_distance),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // box table copy and threshold
  longint box_cen[16][3];
  longint box_rot[16][4];
  longint box_hlf[16][3];
  bit     box_vld[16];
  longint eps_now;

  hit_t pending_hits[$];
  int   fail_cnt, query_cnt, load_cnt, hit_cnt, eps_writes;
  bit   steady;

  function automatic longint fl16(input longint v);
    return v >>> 16;
  endfunction

  function automatic bit slab_test(input int b, input longint org[3], input longint dir[3],
                                   output longint t_near);
    longint ax[3][3];
    longint d[3];
    longint x, y, z, w, tmin, tmax, e, f, af, h, t1, t2, tt;
    x = box_rot[b][0]; y = box_rot[b][1]; z = box_rot[b][2]; w = box_rot[b][3];
    ax[0][0] = ONE - fl16(2 * (y * y + z * z));
    ax[0][1] = fl16(2 * (x * y + w * z));
    ax[0][2] = fl16(2 * (x * z - w * y));
    ax[1][0] = fl16(2 * (x * y - w * z));
    ax[1][1] = ONE - fl16(2 * (x * x + z * z));
    ax[1][2] = fl16(2 * (y * z + w * x));
    ax[2][0] = fl16(2 * (x * z + w * y));
    ax[2][1] = fl16(2 * (y * z - w * x));
    ax[2][2] = ONE - fl16(2 * (x * x + y * y));
    tmin = 0;
    tmax = 64'sh7fff_ffff_ffff_ffff;
    t_near = 0;
    for (int i = 0; i < 3; i++) d[i] = box_cen[b][i] - org[i];
    for (int i = 0; i < 3; i++) begin
      h = box_hlf[b][i];
      e = fl16(ax[i][0] * d[0] + ax[i][1] * d[1] + ax[i][2] * d[2]);
      f = fl16(dir[0] * ax[i][0] + dir[1] * ax[i][1] + dir[2] * ax[i][2]);
      af = (f < 0) ? -f : f;
      if (af > eps_now) begin
        t1 = ((e - h) * ONE) / f;
        t2 = ((e + h) * ONE) / f;
        if (t1 > t2) begin
          tt = t1; t1 = t2; t2 = tt;
        end
        if (t2 < tmax) tmax = t2;
        if (tmin < t1) tmin = t1;
        if (tmax < tmin) return 1'b0;
      end else begin
        if (-e - h > 0 || -e + h < 0) return 1'b0;
      end
    end
    t_near = tmin;
    return 1'b1;
  endfunction

  function automatic void apply_word(input word_t wd);
    longint org[3], dir[3], t, best;
    hit_t r;
    if (wd.action == ACT_LOAD) begin
      box_cen[wd.slot] = '{longint'(wd.px), longint'(wd.py), longint'(wd.pz)};
      box_rot[wd.slot] = '{longint'(wd.vx), longint'(wd.vy), longint'(wd.vz),
                           longint'(wd.vw)};
      box_hlf[wd.slot] = '{longint'(wd.hx), longint'(wd.hy), longint'(wd.hz)};
      box_vld[wd.slot] = 1'b1;
      load_cnt++;
      return;
    end
    org = '{longint'(wd.px), longint'(wd.py), longint'(wd.pz)};
    dir = '{longint'(wd.vx), longint'(wd.vy), longint'(wd.vz)};
    r = '{1'b0, '0, '0};
    best = 0;
    for (int b = 0; b < 16; b++) begin
      if (box_vld[b] && slab_test(b, org, dir, t) && (!r.hit || t < best)) begin
        r.hit = 1'b1;
        best = t;
        r.slot = SLOT_W'(b);
      end
    end
    if (r.hit) begin
      r.distance = (best > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : best[DIST_W-1:0];
      hit_cnt++;
    end
    query_cnt++;
    pending_hits = {pending_hits, r};
  endfunction

  always @(posedge clk) begin
    hit_t x;
    if (rst_n && out_strobe) begin
      if (pending_hits.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result word: hit %0b slot %0d dist %0d",
                                     out_hit_found, out_focus_slot, out_hit_distance);
      end else begin
        x = pending_hits.pop_front();
        if (out_hit_found !== x.hit || out_focus_slot !== x.slot ||
            out_hit_distance !== x.distance) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected hit %0b slot %0d dist %0d, got %0b %0d %0d",
                     x.hit, x.slot, x.distance, out_hit_found, out_focus_slot,
                     out_hit_distance);
        end
      end
    end
  end

  task automatic send_word(input word_t wd);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action <= wd.action; in_slot <= wd.slot;
    in_pos_x <= wd.px; in_pos_y <= wd.py; in_pos_z <= wd.pz;
    in_vec_x <= wd.vx; in_vec_y <= wd.vy; in_vec_z <= wd.vz; in_vec_w <= wd.vw;
    in_half_x <= wd.hx; in_half_y <= wd.hy; in_half_z <= wd.hz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    apply_word(wd);
  endtask

  task automatic drain_all();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_eps(input logic [EPS_W-1:0] v);
    drain_all();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_now = longint'(v);
    eps_writes++;
  endtask

  function automatic word_t load_word(input int s, input longint c[3], input longint q[4],
                                      input longint h[3]);
    word_t wd;
    wd = '{ACT_LOAD, s[SLOT_W-1:0], POS_W'(c[0]), POS_W'(c[1]), POS_W'(c[2]),
           POS_W'(q[0]), POS_W'(q[1]), POS_W'(q[2]), QW_W'(q[3]),
           HALF_W'(h[0]), HALF_W'(h[1]), HALF_W'(h[2])};
    return wd;
  endfunction

  function automatic word_t ray_word(input longint o[3], input longint d[3]);
    word_t wd;
    wd = '{ACT_QUERY, SLOT_W'($urandom), POS_W'(o[0]), POS_W'(o[1]), POS_W'(o[2]),
           POS_W'(d[0]), POS_W'(d[1]), POS_W'(d[2]),
           QW_W'($urandom), HALF_W'($urandom), HALF_W'($urandom), HALF_W'($urandom)};
    return wd;
  endfunction

  function automatic longint near_val(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic word_t noise_word(input int slots);
    word_t wd;
    wd.action = 1'($urandom_range(0, 1));
    wd.slot = SLOT_W'($urandom_range(0, slots - 1));
    wd.px = POS_W'($urandom); wd.py = POS_W'($urandom); wd.pz = POS_W'($urandom);
    wd.vx = POS_W'($urandom); wd.vy = POS_W'($urandom); wd.vz = POS_W'($urandom);
    wd.vw = QW_W'(longint'($urandom_range(0, 131072)) - 65536);
    wd.hx = HALF_W'($urandom); wd.hy = HALF_W'($urandom); wd.hz = HALF_W'($urandom);
    return wd;
  endfunction

  function automatic word_t shaped_box(input int s);
    longint c[3], q[4], h[3];
    for (int i = 0; i < 3; i++) begin
      c[i] = near_val(16 * 65536);
      h[i] = longint'($urandom_range(0, 4 * 65536));
    end
    if ($urandom_range(0, 1)) q = '{0, 0, 0, ONE};
    else q = '{near_val(40000), near_val(40000), near_val(40000), near_val(65536)};
    return load_word(s, c, q, h);
  endfunction

  function automatic word_t aimed_ray(input int slots);
    longint o[3], d[3];
    int s, sh;
    s = $urandom_range(0, slots - 1);
    sh = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      o[i] = near_val(32 * 65536);
      d[i] = ((box_cen[s][i] - o[i]) >>> sh) + near_val(20000);
    end
    if ($urandom_range(0, 7) == 0) d[$urandom_range(0, 2)] = near_val(80);
    return ray_word(o, d);
  endfunction

  task automatic test_directed();
    longint z3[3], u3[3], idq[4];
    z3 = '{0, 0, 0};
    u3 = '{ONE, ONE, ONE};
    idq = '{0, 0, 0, ONE};
    // empty table
    send_word(ray_word(z3, '{ONE, 0, 0}));
    send_word(load_word(0, '{4 * ONE, 0, 0}, idq, u3));
    send_word(ray_word(z3, '{ONE, 0, 0}));
    // tie, earliest slot wins
    send_word(load_word(1, '{4 * ONE, 0, 0}, idq, u3));
    send_word(ray_word(z3, '{ONE, 0, 0}));
    // pointing away, parallel inside and outside, origin inside
    send_word(ray_word(z3, '{-ONE, 0, 0}));
    send_word(ray_word('{4 * ONE, -5 * ONE, 0}, '{0, ONE, 0}));
    send_word(ray_word(z3, '{0, ONE, 0}));
    send_word(ray_word('{4 * ONE, 0, 0}, '{0, 0, ONE}));
    // far hit saturates
    send_word(ray_word(z3, '{100, 0, 0}));
    // non-unit quaternion
    send_word(load_word(2, '{0, 6 * ONE, 0}, '{ONE, 0, 0, ONE}, u3));
    send_word(ray_word(z3, '{0, ONE, 0}));
    // field extremes
    send_word(load_word(3, '{8388607, -8388608, 8388607},
                        '{-8388608, 8388607, -8388608, -65536},
                        '{8388607, 8388607, 8388607}));
    send_word(ray_word('{-8388608, 8388607, -8388608}, '{8388607, -8388608, 8388607}));
    send_word(load_word(3, '{-8388608, 8388607, -8388608},
                        '{8388607, -8388608, 8388607, 65536}, z3));
    send_word(ray_word('{8388607, -8388608, 8388607}, '{-8388608, 8388607, -8388608}));
    send_word(load_word(3, '{0, 0, -4 * ONE}, idq, '{ONE, ONE, 0}));
    send_word(ray_word(z3, '{0, 0, -ONE}));
  endtask

  task automatic test_random_mix(input int n, input int slots);
    int k;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 19);
      if (k < 2) send_word(noise_word(slots));
      else if (k < 10) send_word(shaped_box($urandom_range(0, slots - 1)));
      else send_word(aimed_ray(slots));
    end
    steady = 1'b0;
  endtask

  task automatic test_epsilon_sweep();
    logic [EPS_W-1:0] vals[4];
    vals = '{16'd0, 16'd65535, EPS_W'($urandom), EPS_RESET};
    foreach (vals[i]) begin
      write_eps(vals[i]);
      test_random_mix(180, 4);
    end
  endtask

  task automatic test_full_table();
    drain_all();
    for (int s = 0; s < 16; s++) send_word(shaped_box(s));
    for (int i = 0; i < 12; i++) send_word(aimed_ray(16));
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_data = '0;
    in_action = 1'b0; in_slot = '0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_vec_x = '0; in_vec_y = '0; in_vec_z = '0; in_vec_w = '0;
    in_half_x = '0; in_half_y = '0; in_half_z = '0;
    eps_now = longint'(EPS_RESET);
    steady = 1'b0;
    foreach (box_vld[i]) box_vld[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(180, 4);
    test_epsilon_sweep();
    test_full_table();
    drain_all();
    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d ray queries (%0d hits), %0d threshold writes",
             load_cnt, query_cnt, hit_cnt, eps_writes);
    $display("mismatches: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
